FILE: hw/rtl/rsp_pkg.sv
// Shared types and constants of the Reed-Solomon symbol puncturer.
// Used by rsp_divider, rsp_pattern and rs_symbol_puncturer; depends on nothing.
package rsp_pkg;

    localparam int SYM_W      = 8;
    localparam int POS_W      = 16;
    localparam int ROW_BITS   = 5;
    localparam int ROW_W      = 1 << ROW_BITS;
    localparam int ROW_AW     = POS_W - ROW_BITS;
    localparam int ROWS       = 1 << ROW_AW;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int DIV_W      = 32;
    localparam int DIVR_W     = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SYMBOL_BITS    = 3'd0,
        CFG_CODE_LENGTH    = 3'd1,
        CFG_MESSAGE_LENGTH = 3'd2,
        CFG_RAW_BITS       = 3'd3,
        CFG_FRAME_SYMBOLS  = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [4:0]       symbol_bits;
        logic [7:0]       code_length;
        logic [7:0]       message_length;
        logic [15:0]      raw_bits;
        logic [POS_W-1:0] frame_symbols;
    } rsp_cfg_t;

    typedef struct packed {
        logic             ready;
        logic [POS_W-1:0] fix_next;
    } rsp_status_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_SF_GO,
        ST_SF_WAIT,
        ST_C_GO,
        ST_C_WAIT,
        ST_MUL,
        ST_D_GO,
        ST_D_WAIT,
        ST_POS_GO,
        ST_POS_WAIT,
        ST_MARK_INIT,
        ST_MARK_RD,
        ST_MARK_WR,
        ST_SETTLE,
        ST_RUN
    } rsp_state_t;

endpackage

FILE: hw/rtl/rsp_divider.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on rsp_pkg for the operand widths.
module rsp_divider (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [rsp_pkg::DIV_W-1:0]  dividend,
    input  logic [rsp_pkg::DIVR_W-1:0] divisor,
    output logic                      busy,
    output logic [rsp_pkg::DIV_W-1:0]  quotient,
    output logic [rsp_pkg::DIVR_W-1:0] remainder
);

    localparam int CNT_W = $clog2(rsp_pkg::DIV_W + 1);

    logic [rsp_pkg::DIV_W-1:0]  quo_reg;
    logic [rsp_pkg::DIVR_W-1:0] rem_reg;
    logic [rsp_pkg::DIVR_W-1:0] dvs_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic                       busy_reg;

    logic [rsp_pkg::DIVR_W:0]   trial;
    logic [rsp_pkg::DIVR_W:0]   diff;
    logic                       ge;
    logic [rsp_pkg::DIVR_W-1:0] rem_next;
    logic [rsp_pkg::DIV_W-1:0]  quo_next;

    always_comb begin
        trial    = {rem_reg, quo_reg[rsp_pkg::DIV_W-1]};
        ge       = (trial >= {1'b0, dvs_reg});
        diff     = trial - {1'b0, dvs_reg};
        rem_next = ge ? diff[rsp_pkg::DIVR_W-1:0] : trial[rsp_pkg::DIVR_W-1:0];
        quo_next = {quo_reg[rsp_pkg::DIV_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(rsp_pkg::DIV_W);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign busy      = busy_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

FILE: hw/rtl/rsp_pattern.sv
// Builds the puncturing bitmap from the configuration and serves row lookups.
// Depends on rsp_pkg and rsp_divider.
module rsp_pattern (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        restart,
    input  rsp_pkg::rsp_cfg_t           cfg,
    input  logic [rsp_pkg::POS_W-1:0]   pos,
    input  logic [rsp_pkg::ROW_AW-1:0]  lookup_row,
    output rsp_pkg::rsp_status_t        status,
    output logic [rsp_pkg::ROW_W-1:0]   row_data
);

    rsp_pkg::rsp_state_t state_reg, state_next;

    logic [rsp_pkg::ROW_W-1:0] mem [rsp_pkg::ROWS];

    logic [rsp_pkg::ROW_AW-1:0] clr_reg;
    logic [15:0]                sf_reg;
    logic [15:0]                c_reg;
    logic [7:0]                 rk_reg;
    logic [31:0]                s_reg;
    logic [31:0]                d_reg;
    logic [7:0]                 first_reg;
    logic                       en_reg;
    logic [rsp_pkg::POS_W-1:0]  fix_reg;
    logic [7:0]                 j_reg;
    logic [31:0]                prod_reg;
    logic [rsp_pkg::ROW_W-1:0]  row_q_reg;

    logic                        div_start;
    logic [rsp_pkg::DIV_W-1:0]   div_dividend;
    logic [rsp_pkg::DIVR_W-1:0]  div_divisor;
    logic                        div_busy;
    logic [rsp_pkg::DIV_W-1:0]   div_quo;
    logic [rsp_pkg::DIVR_W-1:0]  div_rem;

    logic [4:0]                  gf;
    logic [31:0]                 q_ceil;
    logic [31:0]                 mark;
    logic                        mark_fits;
    logic [rsp_pkg::ROW_AW-1:0]  mark_row;
    logic [rsp_pkg::ROW_W-1:0]   mark_bit;
    logic                        last_mark;
    logic                        advance;
    logic [rsp_pkg::POS_W:0]     pos_inc;
    logic [23:0]                 nc;
    logic [7:0]                  kr;
    logic [7:0]                  p_val;
    logic [39:0]                 first_prod;

    logic                        mem_we;
    logic [rsp_pkg::ROW_AW-1:0]  mem_waddr;
    logic [rsp_pkg::ROW_W-1:0]   mem_wdata;
    logic [rsp_pkg::ROW_AW-1:0]  mem_raddr;

    rsp_divider u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .busy      (div_busy),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_comb begin
        gf         = (cfg.symbol_bits == 5'd0) ? 5'd1 : cfg.symbol_bits;
        q_ceil     = div_quo + {31'd0, (div_rem != '0)};
        mark       = prod_reg - 32'd1;
        mark_fits  = (mark[31:rsp_pkg::POS_W] == '0);
        mark_row   = mark[rsp_pkg::POS_W-1:rsp_pkg::ROW_BITS];
        mark_bit   = rsp_pkg::ROW_W'(1) << mark[rsp_pkg::ROW_BITS-1:0];
        last_mark  = (j_reg == cfg.code_length);
        pos_inc    = {1'b0, pos} + (rsp_pkg::POS_W+1)'(1);
        nc         = {16'd0, cfg.code_length} * {8'd0, c_reg};
        kr         = cfg.message_length - rk_reg;
        p_val      = cfg.code_length - div_rem[7:0];
        first_prod = {32'd0, first_reg} * {8'd0, d_reg};
        advance    = ((state_reg == rsp_pkg::ST_MARK_RD) && !mark_fits)
                   || (state_reg == rsp_pkg::ST_MARK_WR);
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            rsp_pkg::ST_CLEAR:     if (clr_reg == '1) state_next = rsp_pkg::ST_SF_GO;
            rsp_pkg::ST_SF_GO:     state_next = rsp_pkg::ST_SF_WAIT;
            rsp_pkg::ST_SF_WAIT:   if (!div_busy) state_next = rsp_pkg::ST_C_GO;
            rsp_pkg::ST_C_GO:      state_next = rsp_pkg::ST_C_WAIT;
            rsp_pkg::ST_C_WAIT:    if (!div_busy) state_next = rsp_pkg::ST_MUL;
            rsp_pkg::ST_MUL:       state_next = rsp_pkg::ST_D_GO;
            rsp_pkg::ST_D_GO:      state_next = rsp_pkg::ST_D_WAIT;
            rsp_pkg::ST_D_WAIT:    if (!div_busy) state_next = rsp_pkg::ST_POS_GO;
            rsp_pkg::ST_POS_GO:    state_next = rsp_pkg::ST_POS_WAIT;
            rsp_pkg::ST_POS_WAIT: begin
                if (!div_busy) begin
                    state_next = en_reg ? rsp_pkg::ST_MARK_INIT : rsp_pkg::ST_SETTLE;
                end
            end
            rsp_pkg::ST_MARK_INIT: state_next = rsp_pkg::ST_MARK_RD;
            rsp_pkg::ST_MARK_RD: begin
                if (mark_fits) begin
                    state_next = rsp_pkg::ST_MARK_WR;
                end else if (last_mark) begin
                    state_next = rsp_pkg::ST_SETTLE;
                end
            end
            rsp_pkg::ST_MARK_WR: begin
                state_next = last_mark ? rsp_pkg::ST_SETTLE : rsp_pkg::ST_MARK_RD;
            end
            rsp_pkg::ST_SETTLE:    state_next = rsp_pkg::ST_RUN;
            rsp_pkg::ST_RUN:       state_next = rsp_pkg::ST_RUN;
            default:               state_next = rsp_pkg::ST_CLEAR;
        endcase
        if (restart) begin
            state_next = rsp_pkg::ST_CLEAR;
        end
    end

    // outputs
    always_comb begin
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        mem_we       = 1'b0;
        mem_waddr    = clr_reg;
        mem_wdata    = '0;
        mem_raddr    = lookup_row;
        case (state_reg)
            rsp_pkg::ST_CLEAR: begin
                mem_we = 1'b1;
            end
            rsp_pkg::ST_SF_GO: begin
                div_start    = 1'b1;
                div_dividend = {16'd0, cfg.raw_bits};
                div_divisor  = {11'd0, gf};
            end
            rsp_pkg::ST_C_GO: begin
                div_start    = 1'b1;
                div_dividend = {16'd0, sf_reg};
                div_divisor  = {8'd0, cfg.message_length};
            end
            rsp_pkg::ST_D_GO: begin
                div_start    = 1'b1;
                div_dividend = s_reg;
                div_divisor  = {8'd0, cfg.code_length};
            end
            rsp_pkg::ST_POS_GO: begin
                div_start    = 1'b1;
                div_dividend = {{(rsp_pkg::DIV_W-rsp_pkg::POS_W-1){1'b0}}, pos_inc};
                div_divisor  = cfg.frame_symbols;
            end
            rsp_pkg::ST_MARK_RD: begin
                mem_raddr = mark_row;
            end
            rsp_pkg::ST_MARK_WR: begin
                mem_we    = 1'b1;
                mem_waddr = mark_row;
                mem_wdata = row_q_reg | mark_bit;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rsp_pkg::ST_CLEAR;
            clr_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (restart) begin
                clr_reg <= '0;
            end else if (state_reg == rsp_pkg::ST_CLEAR) begin
                clr_reg <= clr_reg + rsp_pkg::ROW_AW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            rsp_pkg::ST_SF_WAIT: if (!div_busy) sf_reg <= q_ceil[15:0];
            rsp_pkg::ST_C_WAIT: begin
                if (!div_busy) begin
                    c_reg  <= q_ceil[15:0];
                    rk_reg <= div_rem[7:0];
                end
            end
            rsp_pkg::ST_MUL: s_reg <= {8'd0, nc} - {24'd0, kr};
            rsp_pkg::ST_D_WAIT: begin
                if (!div_busy) begin
                    d_reg     <= q_ceil;
                    first_reg <= div_rem[7:0] + 8'd1;
                    en_reg    <= (cfg.code_length != 8'd0) && (cfg.message_length != 8'd0)
                              && (p_val < cfg.message_length);
                end
            end
            rsp_pkg::ST_POS_WAIT: if (!div_busy) fix_reg <= div_rem[rsp_pkg::POS_W-1:0];
            rsp_pkg::ST_MARK_INIT: begin
                prod_reg <= first_prod[31:0];
                j_reg    <= first_reg;
            end
            default: begin
                if (advance) begin
                    prod_reg <= prod_reg + d_reg;
                    j_reg    <= j_reg + 8'd1;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        row_q_reg <= mem[mem_raddr];
    end

    assign status.ready    = (state_reg == rsp_pkg::ST_RUN);
    assign status.fix_next = fix_reg;
    assign row_data        = row_q_reg;

endmodule

FILE: hw/rtl/rs_symbol_puncturer.sv
// Top level of the Reed-Solomon symbol puncturer: registers, position counter,
// stream handshake and result register. Depends on rsp_pkg and rsp_pattern.
//
// Channel  Dir  Ports                                  Item
// s_       in   s_tvalid, s_tready, s_tdata            coded_symbol
// m_       out  m_tvalid, m_tready, m_tdata            kept_symbol
// cfg_wr   in   cfg_wr_en, cfg_wr_index, cfg_wr_data   register write
//
// One symbol per cycle while s_tready is high; the drop decision is one bit of a
// 2048 x 32 bitmap whose row for the next position is read in the same cycle the
// position advances. After reset and after every write to one of the five
// registers the bitmap is rebuilt: a clearing pass over all 2048 rows, four
// divisions, then a read of each candidate mark and a write where it lands in
// the bitmap; s_tready is low meanwhile.
// A result waits in the output register; outside a rebuild s_tready is high
// while it is empty or being taken.
module rs_symbol_puncturer (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [rsp_pkg::CFG_IDX_W-1:0]    cfg_wr_index,
    input  logic [rsp_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [rsp_pkg::SYM_W-1:0]        s_tdata,   // [7:0] coded_symbol
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [rsp_pkg::SYM_W-1:0]        m_tdata    // [7:0] kept_symbol
);

    rsp_pkg::rsp_cfg_t    cfg_reg;
    rsp_pkg::rsp_status_t status;

    logic [rsp_pkg::POS_W-1:0]  pos_reg, pos_next;
    logic                       out_valid_reg;
    logic [rsp_pkg::SYM_W-1:0]  out_data_reg;
    logic                       restart;
    logic                       in_acc;
    logic                       drop;
    logic [rsp_pkg::POS_W:0]    pos_inc;
    logic [rsp_pkg::ROW_W-1:0]  row_data;

    always_comb begin
        case (cfg_wr_index)
            rsp_pkg::CFG_SYMBOL_BITS,
            rsp_pkg::CFG_CODE_LENGTH,
            rsp_pkg::CFG_MESSAGE_LENGTH,
            rsp_pkg::CFG_RAW_BITS,
            rsp_pkg::CFG_FRAME_SYMBOLS: restart = cfg_wr_en;
            default:                    restart = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.symbol_bits    <= 5'd8;
            cfg_reg.code_length    <= 8'd15;
            cfg_reg.message_length <= 8'd7;
            cfg_reg.raw_bits       <= 16'd1024;
            cfg_reg.frame_symbols  <= rsp_pkg::POS_W'(15);
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                rsp_pkg::CFG_SYMBOL_BITS:    cfg_reg.symbol_bits    <= cfg_wr_data[4:0];
                rsp_pkg::CFG_CODE_LENGTH:    cfg_reg.code_length    <= cfg_wr_data[7:0];
                rsp_pkg::CFG_MESSAGE_LENGTH: cfg_reg.message_length <= cfg_wr_data[7:0];
                rsp_pkg::CFG_RAW_BITS:       cfg_reg.raw_bits       <= cfg_wr_data[15:0];
                rsp_pkg::CFG_FRAME_SYMBOLS:
                    cfg_reg.frame_symbols <= cfg_wr_data[rsp_pkg::POS_W-1:0];
                default: cfg_reg <= cfg_reg;
            endcase
        end
    end

    rsp_pattern u_pattern (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .restart    (restart),
        .cfg        (cfg_reg),
        .pos        (pos_reg),
        .lookup_row (pos_next[rsp_pkg::POS_W-1:rsp_pkg::ROW_BITS]),
        .status     (status),
        .row_data   (row_data)
    );

    assign s_tready = status.ready && (!out_valid_reg || m_tready);
    assign in_acc   = s_tvalid && s_tready;
    assign drop     = row_data[pos_reg[rsp_pkg::ROW_BITS-1:0]];

    // position beyond a shortened frame takes the remainder worked out at rebuild
    always_comb begin
        pos_inc  = {1'b0, pos_reg} + (rsp_pkg::POS_W+1)'(1);
        pos_next = pos_reg;
        if (in_acc) begin
            if (cfg_reg.frame_symbols == '0) begin
                pos_next = pos_inc[rsp_pkg::POS_W-1:0];
            end else if (pos_inc > {1'b0, cfg_reg.frame_symbols}) begin
                pos_next = status.fix_next;
            end else if (pos_inc == {1'b0, cfg_reg.frame_symbols}) begin
                pos_next = '0;
            end else begin
                pos_next = pos_inc[rsp_pkg::POS_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            pos_reg <= pos_next;
            if (in_acc && !drop) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc && !drop) begin
            out_data_reg <= s_tdata;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef NO_ASSERTIONS
    a_kept_item_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && !drop) |=> (m_tvalid && (m_tdata == $past(s_tdata))))
        else $error("kept item not presented on m_");

    a_pos_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && (cfg_reg.frame_symbols != '0) && !cfg_wr_en)
        |=> (pos_reg < cfg_reg.frame_symbols))
        else $error("frame position beyond frame length");

    a_rebuild_stalls: assert property (@(posedge aclk) disable iff (!aresetn)
        restart |=> !s_tready)
        else $error("item accepted while pattern rebuilds");
`endif

endmodule

FILE: dv/tb_rs_symbol_puncturer.sv
// Self-checking bench for rs_symbol_puncturer: queued symbols driven on s_, kept symbols
// checked on m_ against a local puncturing model. Depends on rsp_pkg and the RTL only.
module tb_rs_symbol_puncturer;

    localparam int WATCHDOG_LIMIT = 100000;
    localparam int IDLE_PCT = 21;
    localparam logic [rsp_pkg::CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 3'd7;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           cfg_wr_en = 1'b0;
    logic [rsp_pkg::CFG_IDX_W-1:0]  cfg_wr_index = rsp_pkg::CFG_SYMBOL_BITS;
    logic [rsp_pkg::CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [rsp_pkg::SYM_W-1:0]      s_tdata = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [rsp_pkg::SYM_W-1:0]      m_tdata;

    always #5 aclk = ~aclk;

    rs_symbol_puncturer dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata)
    );

    // model registers and puncturing plan
    bit [4:0]  gf_bits;
    bit [7:0]  n_len;
    bit [7:0]  k_len;
    bit [15:0] raw_len;
    bit [15:0] frame_len;
    bit [15:0] frame_pos;
    bit [31:0] spacing;
    bit [7:0]  first_block;
    bit        punct_on;

    bit [rsp_pkg::SYM_W-1:0] symbols_to_send[$];
    bit [rsp_pkg::SYM_W-1:0] kept_due[$];
    bit             steady = 1'b0;
    bit             s_took = 1'b0;
    int             queued_count = 0;
    int             sent_count = 0;
    int             kept_count = 0;
    int             dropped_count = 0;
    int             config_writes = 0;
    int             err_count = 0;
    int             stall_cycles = 0;

    function automatic bit [31:0] div_up(bit [31:0] a, bit [31:0] b);
        return a / b + ((a % b) != 0 ? 32'd1 : 32'd0);
    endfunction

    function automatic void plan_punctures();
        bit [31:0] g, n, k, sf, s, p, fb;
        g = (gf_bits == 0) ? 32'd1 : {27'd0, gf_bits};
        n = {24'd0, n_len};
        k = {24'd0, k_len};
        punct_on = 1'b0;
        spacing = '0;
        first_block = '0;
        if (n == 0 || k == 0) return;
        sf = div_up({16'd0, raw_len}, g);
        s = n * div_up(sf, k) - (k - sf % k);
        spacing = div_up(s, n);
        p = n - s % n;
        fb = n - p + 32'd1;
        first_block = fb[7:0];
        punct_on = (p < k);
    endfunction

    function automatic bit position_punctured(bit [15:0] pos);
        bit [31:0] mark;
        if (!punct_on) return 1'b0;
        for (int unsigned j = first_block; j <= n_len; j++) begin
            mark = j * spacing - 32'd1;
            if (mark == {16'd0, pos}) return 1'b1;
        end
        return 1'b0;
    endfunction

    // returns 1 when the symbol at the current position is dropped
    function automatic bit advance_position();
        bit        drop;
        bit [31:0] nxt;
        drop = position_punctured(frame_pos);
        nxt = {16'd0, frame_pos} + 32'd1;
        if (frame_len != 0) nxt = nxt % {16'd0, frame_len};
        frame_pos = nxt[15:0];
        return drop;
    endfunction

    // driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_took) begin
            if (symbols_to_send.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
                s_tvalid <= 1'b1;
                s_tdata  <= symbols_to_send.pop_front();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        m_tready <= aresetn && (steady || $urandom_range(0, 99) >= IDLE_PCT);
    end

    // monitor and scoreboard
    always @(posedge aclk) begin : monitor
        bit [rsp_pkg::SYM_W-1:0] want;
        if (!aresetn) begin
            s_took <= 1'b0;
        end else begin
            s_took <= s_tvalid && s_tready;
            if (s_tvalid && s_tready) begin
                sent_count++;
                if (advance_position()) begin
                    dropped_count++;
                end else begin
                    kept_due.insert(kept_due.size(), s_tdata);
                end
            end
            if (m_tvalid && m_tready) begin
                kept_count++;
                if (kept_due.size() == 0) begin
                    $error("kept_symbol: expected no item, actual %0h", m_tdata);
                    err_count++;
                end else begin
                    want = kept_due.pop_front();
                    if (m_tdata !== want) begin
                        $error("kept_symbol mismatch: expected %0h, actual %0h", want, m_tdata);
                        err_count++;
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                stall_cycles <= 0;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    task automatic queue_symbol(bit [rsp_pkg::SYM_W-1:0] sym);
        symbols_to_send.insert(symbols_to_send.size(), sym);
        queued_count++;
    endtask

    task automatic queue_random(int count);
        repeat (count) queue_symbol(rsp_pkg::SYM_W'($urandom_range(0, 255)));
    endtask

    task automatic drain();
        while (sent_count != queued_count || kept_due.size() != 0) @(posedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    // writes one register, then waits for the rebuild to finish
    task automatic write_reg(logic [rsp_pkg::CFG_IDX_W-1:0] idx,
                             bit [rsp_pkg::CFG_DATA_W-1:0] value);
        @(negedge aclk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= value;
        case (idx)
            rsp_pkg::CFG_SYMBOL_BITS:    gf_bits   = value[4:0];
            rsp_pkg::CFG_CODE_LENGTH:    n_len     = value[7:0];
            rsp_pkg::CFG_MESSAGE_LENGTH: k_len     = value[7:0];
            rsp_pkg::CFG_RAW_BITS:       raw_len   = value;
            rsp_pkg::CFG_FRAME_SYMBOLS:  frame_len = value;
            default: ;
        endcase
        plan_punctures();
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
        while (!s_tready) @(negedge aclk);
        config_writes++;
    endtask

    task automatic random_setting();
        bit [4:0]  g;
        bit [7:0]  n, k;
        bit [15:0] raw, frame;
        bit [31:0] top;
        int        sel;
        sel = $urandom_range(0, 11);
        g = (sel == 0) ? 5'd0 : (sel == 1) ? 5'd31 : 5'($urandom_range(1, 16));
        sel = $urandom_range(0, 11);
        n = (sel == 0) ? 8'd0 : (sel == 1) ? 8'd255 :
            (sel == 2) ? 8'($urandom_range(1, 255)) : 8'($urandom_range(1, 8));
        sel = $urandom_range(0, 11);
        k = (sel == 0) ? 8'd0 : (sel == 1) ? 8'd255 : 8'($urandom_range(1, 10));
        sel = $urandom_range(0, 11);
        raw = (sel == 0) ? 16'd0 : (sel == 1) ? 16'hFFFF : 16'($urandom_range(1, 30));
        // upper data bits beyond a narrow register are ignored
        write_reg(rsp_pkg::CFG_SYMBOL_BITS,
                  {($urandom_range(0, 3) == 0) ? 11'($urandom) : 11'd0, g});
        write_reg(rsp_pkg::CFG_CODE_LENGTH,
                  {($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'd0, n});
        write_reg(rsp_pkg::CFG_MESSAGE_LENGTH,
                  {($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'd0, k});
        write_reg(rsp_pkg::CFG_RAW_BITS, raw);
        top = {24'd0, n_len} * spacing;
        sel = $urandom_range(0, 9);
        if (sel < 5 && punct_on && top != 0 && top <= 300) begin
            frame = top[15:0] + 16'($urandom_range(0, 2));
        end else if (sel < 7) begin
            frame = 16'($urandom_range(1, 40));
        end else if (sel == 7) begin
            frame = 16'd0;
        end else if (sel == 8) begin
            frame = 16'hFFFF;
        end else begin
            frame = 16'($urandom_range(1, 65535));
        end
        write_reg(rsp_pkg::CFG_FRAME_SYMBOLS, frame);
    endtask

    initial begin
        gf_bits   = 5'd8;
        n_len     = 8'd15;
        k_len     = 8'd7;
        raw_len   = 16'd1024;
        frame_len = 16'd15;
        frame_pos = '0;
        plan_punctures();
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;

        // reset setting: nothing punctured inside a 15-symbol frame
        queue_symbol(8'h00);
        queue_symbol(8'hFF);
        queue_symbol(8'h55);
        queue_symbol(8'hAA);
        queue_symbol(8'h0F);
        queue_symbol(8'hF0);
        queue_symbol(8'h3C);
        queue_symbol(8'hC3);
        queue_symbol(8'h99);
        drain();

        // zero field size acts as one; positions 5 and 7 of an 8-symbol frame dropped,
        // counter starts beyond the new frame length
        write_reg(rsp_pkg::CFG_SYMBOL_BITS, 16'd0);
        write_reg(rsp_pkg::CFG_CODE_LENGTH, 16'd4);
        write_reg(rsp_pkg::CFG_MESSAGE_LENGTH, 16'd3);
        write_reg(rsp_pkg::CFG_RAW_BITS, 16'd4);
        write_reg(rsp_pkg::CFG_FRAME_SYMBOLS, 16'd8);
        queue_random(12);
        drain();

        // zero code length, free-running counter; then zero message length
        write_reg(rsp_pkg::CFG_CODE_LENGTH, 16'd0);
        write_reg(rsp_pkg::CFG_FRAME_SYMBOLS, 16'd0);
        queue_random(3);
        drain();
        write_reg(rsp_pkg::CFG_CODE_LENGTH, 16'd4);
        write_reg(rsp_pkg::CFG_MESSAGE_LENGTH, 16'd0);
        write_reg(CFG_UNUSED_INDEX, 16'($urandom));
        queue_random(3);
        drain();

        for (int phase = 0; phase < 7; phase++) begin
            if (phase == 0) begin
                write_reg(rsp_pkg::CFG_SYMBOL_BITS, 16'hFFFF);
                write_reg(rsp_pkg::CFG_CODE_LENGTH, 16'd255);
                write_reg(rsp_pkg::CFG_MESSAGE_LENGTH, 16'd255);
                write_reg(rsp_pkg::CFG_RAW_BITS, 16'hFFFF);
                write_reg(rsp_pkg::CFG_FRAME_SYMBOLS, 16'hFFFF);
            end else if (phase == 1) begin
                write_reg(rsp_pkg::CFG_SYMBOL_BITS, 16'd16);
                write_reg(rsp_pkg::CFG_CODE_LENGTH, 16'd6);
                write_reg(rsp_pkg::CFG_MESSAGE_LENGTH, 16'd4);
                write_reg(rsp_pkg::CFG_RAW_BITS, 16'd200);
                write_reg(rsp_pkg::CFG_FRAME_SYMBOLS, 16'd1);
            end else begin
                random_setting();
            end
            steady = (phase == 3);
            if (phase == 4) begin
                // sender holds off until every kept item is out
                queue_random(50);
                drain();
                queue_random(50);
            end else begin
                queue_random(100);
            end
            drain();
        end
        steady = 1'b0;

        drain();
        repeat (20) @(negedge aclk);
        $display("%0d symbols through %0d register writes: %0d kept, %0d punctured",
                 sent_count, config_writes, kept_count, dropped_count);
        if (err_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
